### rtl/core/bb3_pkg.sv
// ============================================================================
// bb3_pkg - shared types and constants for the 3x3 box blur stream
// Sizes, position widths, the reciprocal used for the divide by nine, and
// the configuration register codes.
// ============================================================================
`default_nettype none

package bb3_pkg;

    localparam int MAX_WIDTH   = 1024;
    localparam int MAX_HEIGHT  = 1024;
    localparam int SAMPLE_BITS = 16;

    localparam int ADDR_BITS = $clog2(MAX_WIDTH);
    localparam int POS_BITS  = 10;
    localparam int SIZE_BITS = 11;

    // three samples per column, nine per window
    localparam int COL_BITS  = SAMPLE_BITS + 2;
    localparam int PAIR_BITS = COL_BITS + 1;
    localparam int SUM_BITS  = SAMPLE_BITS + 4;

    // floor(x / 9) == (x * RECIP) >> RECIP_SHIFT for every x below 2**SUM_BITS
    localparam int RECIP_SHIFT = SUM_BITS + 3;
    localparam int RECIP_BITS  = SUM_BITS;
    localparam logic [RECIP_BITS-1:0] RECIP =
        RECIP_BITS'(((64'd1 << RECIP_SHIFT) + 64'd8) / 64'd9);
    localparam int PROD_BITS = SUM_BITS + RECIP_BITS;

    localparam logic [0:0] CFG_FRAME_WIDTH  = 1'b0;
    localparam logic [0:0] CFG_FRAME_HEIGHT = 1'b1;

    localparam logic [SIZE_BITS-1:0] SIZE_RESET = SIZE_BITS'(512);
    localparam logic [SIZE_BITS-1:0] SIZE_MIN   = SIZE_BITS'(3);

    typedef struct packed {
        logic                result;
        logic [POS_BITS-1:0] column;
        logic [POS_BITS-1:0] row;
        logic                last;
    } meta_t;

    function automatic logic [SIZE_BITS-1:0] clamp_size(
        input logic [SIZE_BITS-1:0] v,
        input logic [SIZE_BITS-1:0] hi
    );
        logic [SIZE_BITS-1:0] res;
        begin
            if (v < SIZE_MIN) begin
                res = SIZE_MIN;
            end else if (v > hi) begin
                res = hi;
            end else begin
                res = v;
            end
            return res;
        end
    endfunction

endpackage

`default_nettype wire

### rtl/core/bb3_ram.sv
// ============================================================================
// bb3_ram - generic simple dual-port RAM
// One write port, one read port, read data registered.
// ============================================================================
`default_nettype none

module bb3_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem_reg[rd_addr];
        end
    end

endmodule

`default_nettype wire

### rtl/core/bb3_line_buf.sv
// ============================================================================
// bb3_line_buf - raster position tracking and the two line stores
// Read both rows above at the incoming column, write them back shifted by
// one row, and forward the pending write when consecutive transfers share
// a column.
// ============================================================================
`default_nettype none

module bb3_line_buf (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             s_valid,
    output logic                                  s_ready,
    input  wire logic [bb3_pkg::SAMPLE_BITS-1:0]  pixel,
    input  wire logic                             frame_start,
    input  wire logic [bb3_pkg::SIZE_BITS-1:0]    width,
    input  wire logic [bb3_pkg::SIZE_BITS-1:0]    height,
    output logic                                  o_valid,
    input  wire logic                             o_ready,
    output logic      [bb3_pkg::SAMPLE_BITS-1:0]  o_up,
    output logic      [bb3_pkg::SAMPLE_BITS-1:0]  o_mid,
    output logic      [bb3_pkg::SAMPLE_BITS-1:0]  o_px,
    output bb3_pkg::meta_t                        o_meta
);

    localparam int SB = bb3_pkg::SAMPLE_BITS;
    localparam int PB = bb3_pkg::POS_BITS;
    localparam int ZB = bb3_pkg::SIZE_BITS;
    localparam int AB = bb3_pkg::ADDR_BITS;

    logic [PB-1:0] col_reg, col_next;
    logic [PB-1:0] row_reg, row_next;

    logic                 st1_v_reg;
    logic [SB-1:0]        st1_px_reg;
    logic [AB-1:0]        st1_addr_reg;
    bb3_pkg::meta_t       st1_meta_reg;
    logic                 fwd_v_reg;
    logic [2*SB-1:0]      fwd_data_reg;

    logic [PB-1:0]   c, r;
    logic [ZB-1:0]   c_inc, r_inc;
    logic            accept, st1_adv, fwd_next;
    bb3_pkg::meta_t  meta_in;
    logic [2*SB-1:0] ram_rd, rows_rd, wr_data;

    assign accept  = s_valid && s_ready;
    assign st1_adv = st1_v_reg && o_ready;
    assign s_ready = !st1_v_reg || o_ready;

    // position of the incoming pixel
    always_comb begin
        c     = frame_start ? '0 : col_reg;
        r     = frame_start ? '0 : row_reg;
        c_inc = ZB'(c) + ZB'(1);
        r_inc = ZB'(r) + ZB'(1);

        if (c_inc >= width) begin
            col_next = '0;
            row_next = (r_inc >= height) ? '0 : r_inc[PB-1:0];
        end else begin
            col_next = c_inc[PB-1:0];
            row_next = (ZB'(r) >= height) ? '0 : r;
        end

        meta_in.result = (r >= PB'(2)) && (c >= PB'(2)) &&
                         (ZB'(r) < height) && (ZB'(c) < width);
        meta_in.column = c - PB'(1);
        meta_in.row    = r - PB'(1);
        meta_in.last   = (ZB'(c) == width - ZB'(1)) && (ZB'(r) == height - ZB'(1));
    end

    // upper row in the high half, middle row in the low half
    assign rows_rd = fwd_v_reg ? fwd_data_reg : ram_rd;
    assign wr_data = {rows_rd[SB-1:0], st1_px_reg};
    assign fwd_next = st1_adv && (st1_addr_reg == AB'(c));

    bb3_ram #(
        .WIDTH (2 * SB),
        .DEPTH (bb3_pkg::MAX_WIDTH)
    ) u_lines (
        .aclk    (aclk),
        .wr_en   (st1_adv),
        .wr_addr (st1_addr_reg),
        .wr_data (wr_data),
        .rd_en   (accept),
        .rd_addr (AB'(c)),
        .rd_data (ram_rd)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg   <= '0;
            row_reg   <= '0;
            st1_v_reg <= 1'b0;
            fwd_v_reg <= 1'b0;
        end else begin
            if (accept) begin
                col_reg   <= col_next;
                row_reg   <= row_next;
                st1_v_reg <= 1'b1;
                fwd_v_reg <= fwd_next;
            end else if (st1_adv) begin
                st1_v_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            st1_px_reg   <= pixel;
            st1_addr_reg <= AB'(c);
            st1_meta_reg <= meta_in;
            fwd_data_reg <= wr_data;
        end
    end

    assign o_valid = st1_v_reg;
    assign o_up    = rows_rd[2*SB-1:SB];
    assign o_mid   = rows_rd[SB-1:0];
    assign o_px    = st1_px_reg;
    assign o_meta  = st1_meta_reg;

`ifndef SYNTHESIS
    a_fwd_same_column: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && st1_adv && st1_addr_reg == AB'(c)) |=> fwd_v_reg)
        else $error("same-column write not forwarded");
    a_no_accept_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (st1_v_reg && !o_ready) |-> !accept)
        else $error("transfer taken while line stage stalled");
`endif

endmodule

`default_nettype wire

### rtl/core/bb3_mean.sv
// ============================================================================
// bb3_mean - column sums, window sum and divide by nine
// Keep the two previous column sums, add the window, then multiply by the
// reciprocal of nine and hold the result in the output register.
// ============================================================================
`default_nettype none

module bb3_mean (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             i_valid,
    output logic                                  i_ready,
    input  wire logic [bb3_pkg::SAMPLE_BITS-1:0]  i_up,
    input  wire logic [bb3_pkg::SAMPLE_BITS-1:0]  i_mid,
    input  wire logic [bb3_pkg::SAMPLE_BITS-1:0]  i_px,
    input  wire bb3_pkg::meta_t                   i_meta,
    output logic                                  m_valid,
    input  wire logic                             m_ready,
    output logic      [bb3_pkg::SAMPLE_BITS-1:0]  m_value,
    output bb3_pkg::meta_t                        m_meta
);

    localparam int SB  = bb3_pkg::SAMPLE_BITS;
    localparam int CB  = bb3_pkg::COL_BITS;
    localparam int PRB = bb3_pkg::PAIR_BITS;
    localparam int UB  = bb3_pkg::SUM_BITS;
    localparam int MB  = bb3_pkg::PROD_BITS;
    localparam int RS  = bb3_pkg::RECIP_SHIFT;

    logic [CB-1:0]  cs_old_reg, cs_new_reg;
    logic           s2_v_reg, s3_v_reg, s4_v_reg, out_v_reg;
    logic [PRB-1:0] s2_pair_reg;
    logic [CB-1:0]  s2_col_reg;
    logic [UB-1:0]  s3_sum_reg;
    logic [MB-1:0]  s4_prod_reg;
    logic [SB-1:0]  out_value_reg;
    bb3_pkg::meta_t s2_meta_reg, s3_meta_reg, s4_meta_reg, out_meta_reg;

    logic          out_rdy, s4_rdy, s3_rdy, accept;
    logic [CB-1:0] col;

    assign out_rdy = !out_v_reg || m_ready;
    assign s4_rdy  = !s4_v_reg || out_rdy;
    assign s3_rdy  = !s3_v_reg || s4_rdy;
    assign i_ready = !s2_v_reg || s3_rdy;
    assign accept  = i_valid && i_ready;

    assign col = CB'(i_up) + CB'(i_mid) + CB'(i_px);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cs_old_reg <= '0;
            cs_new_reg <= '0;
            s2_v_reg   <= 1'b0;
            s3_v_reg   <= 1'b0;
            s4_v_reg   <= 1'b0;
            out_v_reg  <= 1'b0;
        end else begin
            // every pixel shifts the window, results or not
            if (accept) begin
                cs_old_reg <= cs_new_reg;
                cs_new_reg <= col;
            end
            if (i_ready) begin
                s2_v_reg <= accept && i_meta.result;
            end
            if (s3_rdy) begin
                s3_v_reg <= s2_v_reg;
            end
            if (s4_rdy) begin
                s4_v_reg <= s3_v_reg;
            end
            if (out_rdy) begin
                out_v_reg <= s4_v_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s2_pair_reg <= PRB'(cs_old_reg) + PRB'(cs_new_reg);
            s2_col_reg  <= col;
            s2_meta_reg <= i_meta;
        end
        if (s3_rdy && s2_v_reg) begin
            s3_sum_reg  <= UB'(s2_pair_reg) + UB'(s2_col_reg);
            s3_meta_reg <= s2_meta_reg;
        end
        if (s4_rdy && s3_v_reg) begin
            s4_prod_reg <= MB'(s3_sum_reg) * MB'(bb3_pkg::RECIP);
            s4_meta_reg <= s3_meta_reg;
        end
        if (out_rdy && s4_v_reg) begin
            out_value_reg <= s4_prod_reg[RS+SB-1:RS];
            out_meta_reg  <= s4_meta_reg;
        end
    end

    assign m_valid = out_v_reg;
    assign m_value = out_value_reg;
    assign m_meta  = out_meta_reg;

`ifndef SYNTHESIS
    a_quotient_fits: assert property (@(posedge aclk) disable iff (!aresetn)
        s4_v_reg |-> (s4_prod_reg[MB-1:RS+SB] == '0))
        else $error("mean exceeds sample range");
    a_stall_means_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !i_ready |-> (s2_v_reg && s3_v_reg && s4_v_reg && out_v_reg))
        else $error("input stalled with a bubble in the pipeline");
`endif

endmodule

`default_nettype wire

### rtl/core/box_blur_3x3_stream.sv
// ============================================================================
// box_blur_3x3_stream - streaming 3x3 mean filter for one colour channel
// Raster pixels in, the truncated mean of each interior 3x3 neighborhood out,
// tagged with the center pixel's column and row.
// ============================================================================
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+----------------------------------
//  s_      | in        | s_valid / s_ready   | pixel_value, frame_start
//  m_      | out       | m_valid / m_ready   | blurred_value, out_column, out_row,
//          |           |                     | frame_last
//  cfg_    | in        | cfg_valid/cfg_ready | cfg_index, cfg_data
//
//  One pixel transfer per cycle sustained while m_ready holds; a result passes
//  the st1, s2, s3, s4 and out registers. The line store is one RAM with a
//  registered read port, read at the pixel's column on transfer and written
//  back as st1 advances; same-column back-to-back pixels take the forwarded write.
//  Reset clears the position counters, the window and all valid flags; the
//  line store is not cleared and needs no clearing pass.
//  A stalled m_ channel fills the pipeline registers before s_ready drops.
//  Configuration is always ready; sizes are clamped to 3..1024 when written.
// ============================================================================
`default_nettype none

module box_blur_3x3_stream (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    // pixel input
    input  wire logic                             s_valid,
    output logic                                  s_ready,
    input  wire logic [bb3_pkg::SAMPLE_BITS-1:0]  s_pixel_value,
    input  wire logic                             s_frame_start,
    // result output
    output logic                                  m_valid,
    input  wire logic                             m_ready,
    output logic      [bb3_pkg::SAMPLE_BITS-1:0]  m_blurred_value,
    output logic      [bb3_pkg::POS_BITS-1:0]     m_out_column,
    output logic      [bb3_pkg::POS_BITS-1:0]     m_out_row,
    output logic                                  m_frame_last,
    // configuration writes
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [0:0]                       cfg_index,
    input  wire logic [bb3_pkg::SIZE_BITS-1:0]    cfg_data
);

    localparam int SB = bb3_pkg::SAMPLE_BITS;
    localparam int ZB = bb3_pkg::SIZE_BITS;

    // stored already clamped, so the datapath never sees an illegal size
    logic [ZB-1:0] width_reg;
    logic [ZB-1:0] height_reg;

    logic           lb_valid, lb_ready;
    logic [SB-1:0]  lb_up, lb_mid, lb_px;
    bb3_pkg::meta_t lb_meta, out_meta;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= bb3_pkg::SIZE_RESET;
            height_reg <= bb3_pkg::SIZE_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                bb3_pkg::CFG_FRAME_WIDTH: begin
                    width_reg <= bb3_pkg::clamp_size(cfg_data, ZB'(bb3_pkg::MAX_WIDTH));
                end
                bb3_pkg::CFG_FRAME_HEIGHT: begin
                    height_reg <= bb3_pkg::clamp_size(cfg_data, ZB'(bb3_pkg::MAX_HEIGHT));
                end
                default: begin
                    // drop writes to unknown registers
                end
            endcase
        end
    end

    // position tracking and line store read-modify-write
    bb3_line_buf u_line_buf (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .pixel       (s_pixel_value),
        .frame_start (s_frame_start),
        .width       (width_reg),
        .height      (height_reg),
        .o_valid     (lb_valid),
        .o_ready     (lb_ready),
        .o_up        (lb_up),
        .o_mid       (lb_mid),
        .o_px        (lb_px),
        .o_meta      (lb_meta)
    );

    // window sum, divide by nine, output register
    bb3_mean u_mean (
        .aclk    (aclk),
        .aresetn (aresetn),
        .i_valid (lb_valid),
        .i_ready (lb_ready),
        .i_up    (lb_up),
        .i_mid   (lb_mid),
        .i_px    (lb_px),
        .i_meta  (lb_meta),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_value (m_blurred_value),
        .m_meta  (out_meta)
    );

    assign m_out_column = out_meta.column;
    assign m_out_row    = out_meta.row;
    assign m_frame_last = out_meta.last;

`ifndef SYNTHESIS
    a_width_legal: assert property (@(posedge aclk) disable iff (!aresetn)
        (width_reg >= bb3_pkg::SIZE_MIN) && (width_reg <= ZB'(bb3_pkg::MAX_WIDTH)) &&
        (height_reg >= bb3_pkg::SIZE_MIN) && (height_reg <= ZB'(bb3_pkg::MAX_HEIGHT)))
        else $error("frame size register out of range");
`endif

endmodule

`default_nettype wire
